// ----- rtl/ldtu_pkg.sv -----
// Shared constants and the month table for the local date to UTC seconds unit.
`default_nettype none

package ldtu_pkg;

    localparam int unsigned YearW   = 12;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned DayW    = 5;
    localparam int unsigned HourW   = 5;
    localparam int unsigned MinuteW = 6;
    localparam int unsigned SecondW = 6;
    localparam int unsigned ZoneW   = 17;
    localparam int unsigned UtcW    = 33;

    localparam logic [YearW-1:0]  EpochYear  = 12'd1970;
    localparam logic [MonthW-1:0] AprilIdx   = 4'd3;
    localparam logic [MonthW-1:0] OctoberIdx = 4'd9;

    // (4 + days before the month's reference day) mod 7, for April 1 and October 31
    localparam logic [YearW-1:0] AprilWdayK   = 12'd3;
    localparam logic [YearW-1:0] OctoberWdayK = 12'd6;

    localparam logic [8:0] AprilFirstYday   = 9'd90;
    localparam logic [8:0] OctoberLastYday  = 9'd303;

    // Register indexes of the configuration port
    typedef enum logic [0:0] {
        CFG_ZONE_OFFSET_WEST = 1'b0,
        CFG_DST_ENABLED      = 1'b1
    } t_cfg_idx;

    // Days before the start of each month, non-leap year, index 0 is January
    function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] mi);
        logic [8:0] d;
        unique case (mi)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd365;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/local_date_to_utc_seconds_unit.sv -----
// Top level: pipelined local calendar date and time to UTC seconds converter.
`default_nettype none

// Converts a local date and time into seconds since 1970-01-01 UTC, adding the
// configured zone offset (seconds west) and, when enabled, subtracting one hour
// under the old US daylight saving rule (all of May to September, April from the
// first Sunday 02:00, October through the last Sunday 02:00). Years before 1970
// return -1 with o_before_epoch set. The unit is a six-stage pipeline with a
// register at each stage, and one transaction can be accepted every cycle while
// the output is not stalled. Stalls on the output ripple back stage by stage, so
// empty stages keep filling while the output waits. Configuration writes take
// effect immediately and should only be issued while the pipeline is empty.
module local_date_to_utc_seconds_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration
    input  wire                          i_cfg_wr_en,
    input  wire [0:0]                    i_cfg_index,
    input  wire [ldtu_pkg::ZoneW-1:0]    i_cfg_wdata,
    // input transactions
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [ldtu_pkg::YearW-1:0]    i_year,
    input  wire [ldtu_pkg::MonthW-1:0]   i_month,
    input  wire [ldtu_pkg::DayW-1:0]     i_day,
    input  wire [ldtu_pkg::HourW-1:0]    i_hour,
    input  wire [ldtu_pkg::MinuteW-1:0]  i_minute,
    input  wire [ldtu_pkg::SecondW-1:0]  i_second,
    // result transactions
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic signed [ldtu_pkg::UtcW-1:0] o_utc_seconds,
    output logic                         o_before_epoch,
    output logic                         o_dst_applied
);
    import ldtu_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [ZoneW-1:0] r_zone_offset_west;
    logic                    r_dst_enabled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_offset_west <= '0;
            r_dst_enabled      <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ZONE_OFFSET_WEST: r_zone_offset_west <= $signed(i_cfg_wdata);
                CFG_DST_ENABLED:      r_dst_enabled      <= i_cfg_wdata[0];
                default:              r_dst_enabled      <= r_dst_enabled;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and per-stage advance
    // ------------------------------------------------------------------
    logic [5:0] r_vld;
    logic [5:0] en;

    always_comb begin
        en[5] = !r_vld[5] || i_ready;
        en[4] = !r_vld[4] || en[5];
        en[3] = !r_vld[3] || en[4];
        en[2] = !r_vld[2] || en[3];
        en[1] = !r_vld[1] || en[2];
        en[0] = !r_vld[0] || en[1];
    end

    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            if (en[1]) r_vld[1] <= r_vld[0];
            if (en[2]) r_vld[2] <= r_vld[1];
            if (en[3]) r_vld[3] <= r_vld[2];
            if (en[4]) r_vld[4] <= r_vld[3];
            if (en[5]) r_vld[5] <= r_vld[4];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: year offset, clamped month, day of year, hour-minute
    // ------------------------------------------------------------------
    logic [MonthW-1:0]       mon_c;
    logic [MonthW-1:0]       mi_c;
    logic                    leap_c;
    logic signed [9:0]       yday_c;
    logic [10:0]             hm_c;

    logic                    r1_before;
    logic [YearW-1:0]        r1_ye;
    logic                    r1_leap;
    logic signed [9:0]       r1_yday;
    logic [10:0]             r1_hm;
    logic [SecondW-1:0]      r1_second;
    logic                    r1_apr;
    logic                    r1_oct;
    logic                    r1_summer;

    always_comb begin
        priority if (i_month == 4'd0) begin
            mon_c = 4'd1;
        end else if (i_month > 4'd12) begin
            mon_c = 4'd12;
        end else begin
            mon_c = i_month;
        end
        mi_c   = mon_c - 4'd1;
        leap_c = (i_year[1:0] == 2'b00);
        yday_c = $signed({1'b0, days_before_month(mi_c)})
               + $signed({5'b0, i_day})
               - 10'sd1
               + $signed({9'b0, (leap_c && (mi_c > 4'd1))});
        hm_c   = {6'b0, i_hour} * 11'd60 + {5'b0, i_minute};
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_before <= (i_year < EpochYear);
            r1_ye     <= i_year - EpochYear;
            r1_leap   <= leap_c;
            r1_yday   <= yday_c;
            r1_hm     <= hm_c;
            r1_second <= i_second;
            r1_apr    <= (mi_c == AprilIdx);
            r1_oct    <= (mi_c == OctoberIdx);
            r1_summer <= (mi_c > AprilIdx) && (mi_c < OctoberIdx);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: days since epoch, seconds of day, weekday sum
    // ------------------------------------------------------------------
    logic [12:0]             ye_p1_c;
    logic [10:0]             leaps_c;
    logic signed [20:0]      days_c;
    logic [16:0]             sod_c;
    logic [YearW-1:0]        wsum_c;

    logic                    r2_before;
    logic                    r2_leap;
    logic signed [9:0]       r2_yday;
    logic signed [20:0]      r2_days;
    logic [16:0]             r2_sod;
    logic [YearW-1:0]        r2_wsum;
    logic                    r2_apr;
    logic                    r2_oct;
    logic                    r2_summer;

    always_comb begin
        ye_p1_c = {1'b0, r1_ye} + 13'd1;
        leaps_c = ye_p1_c[12:2];
        days_c  = $signed({9'b0, r1_ye} * 21'd365)
                + $signed({10'b0, leaps_c})
                + {{11{r1_yday[9]}}, r1_yday};
        sod_c   = {6'b0, r1_hm} * 17'd60 + {11'b0, r1_second};
        // 365 = 1 mod 7, so the weekday needs only ye plus the leap count
        wsum_c  = r1_ye + {1'b0, leaps_c} + {11'b0, r1_leap}
                + (r1_apr ? AprilWdayK : OctoberWdayK);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_before <= r1_before;
            r2_leap   <= r1_leap;
            r2_yday   <= r1_yday;
            r2_days   <= days_c;
            r2_sod    <= sod_c;
            r2_wsum   <= wsum_c;
            r2_apr    <= r1_apr;
            r2_oct    <= r1_oct;
            r2_summer <= r1_summer;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: scale days to seconds, weekday mod 7
    // ------------------------------------------------------------------
    logic signed [38:0]      prod_c;
    logic [4:0]              oct_sum_c;
    logic [3:0]              fold_c;
    logic [2:0]              wday_c;

    logic                    r3_before;
    logic                    r3_leap;
    logic signed [9:0]       r3_yday;
    logic signed [UtcW-1:0]  r3_prod;
    logic [16:0]             r3_sod;
    logic [2:0]              r3_wday;
    logic                    r3_apr;
    logic                    r3_oct;
    logic                    r3_summer;

    always_comb begin
        prod_c    = r2_days * 39'sd86400;
        // 8 = 1 mod 7: sum the octal digits, fold once more, then one correction
        oct_sum_c = {2'b0, r2_wsum[2:0]} + {2'b0, r2_wsum[5:3]}
                  + {2'b0, r2_wsum[8:6]} + {2'b0, r2_wsum[11:9]};
        fold_c    = {1'b0, oct_sum_c[2:0]} + {2'b0, oct_sum_c[4:3]};
        wday_c    = (fold_c >= 4'd7) ? 3'(fold_c - 4'd7) : fold_c[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_before <= r2_before;
            r3_leap   <= r2_leap;
            r3_yday   <= r2_yday;
            r3_prod   <= prod_c[UtcW-1:0];
            r3_sod    <= r2_sod;
            r3_wday   <= wday_c;
            r3_apr    <= r2_apr;
            r3_oct    <= r2_oct;
            r3_summer <= r2_summer;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: switchover Sunday and day distance to it
    // ------------------------------------------------------------------
    logic [8:0]              bday_c;
    logic signed [9:0]       ddiff_c;

    logic                    r4_before;
    logic signed [6:0]       r4_ddiff;
    logic signed [UtcW-1:0]  r4_prod;
    logic [16:0]             r4_sod;
    logic                    r4_apr;
    logic                    r4_oct;
    logic                    r4_summer;

    always_comb begin
        if (r3_apr) begin
            // first Sunday on or after April 1
            bday_c = AprilFirstYday + {8'b0, r3_leap}
                   + ((r3_wday == 3'd0) ? 9'd0 : {6'b0, 3'(3'd7 - r3_wday)});
        end else begin
            // last Sunday on or before October 31
            bday_c = OctoberLastYday + {8'b0, r3_leap} - {6'b0, r3_wday};
        end
        ddiff_c = r3_yday - $signed({1'b0, bday_c});
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_before <= r3_before;
            r4_ddiff  <= ddiff_c[6:0];
            r4_prod   <= r3_prod;
            r4_sod    <= r3_sod;
            r4_apr    <= r3_apr;
            r4_oct    <= r3_oct;
            r4_summer <= r3_summer;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: DST decision, zone offset
    // ------------------------------------------------------------------
    logic signed [23:0]      rel_c;
    logic                    applied_c;

    logic                    r5_before;
    logic                    r5_applied;
    logic signed [UtcW-1:0]  r5_sum;
    logic [16:0]             r5_sod;

    always_comb begin
        // seconds from the 02:00 switchover instant to now
        rel_c     = {{17{r4_ddiff[6]}}, r4_ddiff} * 24'sd86400
                  + $signed({7'b0, r4_sod}) - 24'sd7200;
        applied_c = r_dst_enabled && !r4_before
                 && (r4_summer || (r4_apr && !rel_c[23])
                     || (r4_oct && (rel_c[23] || (rel_c == 24'sd0))));
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r5_before  <= r4_before;
            r5_applied <= applied_c;
            r5_sum     <= r4_prod + {{(UtcW-ZoneW){r_zone_offset_west[ZoneW-1]}},
                                     r_zone_offset_west};
            r5_sod     <= r4_sod;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: final result, output register
    // ------------------------------------------------------------------
    logic signed [UtcW-1:0]  r6_utc;
    logic                    r6_before;
    logic                    r6_applied;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r6_before  <= r5_before;
            r6_applied <= r5_applied;
            if (r5_before) begin
                r6_utc <= '1;
            end else begin
                r6_utc <= r5_sum + $signed({16'b0, r5_sod})
                        - (r5_applied ? 33'sd3600 : 33'sd0);
            end
        end
    end

    assign o_valid        = r_vld[5];
    assign o_utc_seconds  = r6_utc;
    assign o_before_epoch = r6_before;
    assign o_dst_applied  = r6_applied;

endmodule

`default_nettype wire

// ----- rtl/ldtu_chk.sv -----
// Port-level checker for the local date to UTC seconds unit, with its bind.
`default_nettype none

module ldtu_chk (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire [0:0]                    i_cfg_index,
    input  wire [ldtu_pkg::ZoneW-1:0]    i_cfg_wdata,
    input  wire                          o_ready,
    input  wire                          o_valid,
    input  wire                          i_ready,
    input  wire [ldtu_pkg::UtcW-1:0]     o_utc_seconds,
    input  wire                          o_before_epoch,
    input  wire                          o_dst_applied
);
    import ldtu_pkg::*;

    // shadow of the DST enable as seen on the configuration port
    logic r_dst_shadow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_shadow <= 1'b0;
        end else if (i_cfg_wr_en && (i_cfg_index == CFG_DST_ENABLED)) begin
            r_dst_shadow <= i_cfg_wdata[0];
        end
    end

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_utc_seconds)
                                && $stable(o_before_epoch) && $stable(o_dst_applied))
        else $error("result changed while stalled");

    // pre-epoch results are -1 with no DST correction
    a_before_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_before_epoch |-> (o_utc_seconds == '1) && !o_dst_applied)
        else $error("bad pre-epoch result");

    // a DST correction only happens with DST enabled
    a_dst_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dst_applied |-> r_dst_shadow)
        else $error("DST applied while disabled");

    // with an empty output register the input side is never blocked
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

endmodule

bind local_date_to_utc_seconds_unit ldtu_chk u_ldtu_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_wr_en    (i_cfg_wr_en),
    .i_cfg_index    (i_cfg_index),
    .i_cfg_wdata    (i_cfg_wdata),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_utc_seconds  (o_utc_seconds),
    .o_before_epoch (o_before_epoch),
    .o_dst_applied  (o_dst_applied)
);

`default_nettype wire
